// ===== rtl/box_filter_mip_downsampler_unit_macros.svh =====
// Assertion macros for the box filter mip downsampler.
`ifndef BOX_FILTER_MIP_DOWNSAMPLER_UNIT_MACROS_SVH
`define BOX_FILTER_MIP_DOWNSAMPLER_UNIT_MACROS_SVH

`ifndef SYNTH

`define BFMD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BFMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BFMD_ASSERT(lbl, clk, rst_n, prop, msg)

`define BFMD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/bfmd_pkg.sv =====
// Package: widths and register map of the box filter mip downsampler.
package bfmd_pkg;

	localparam int unsigned MAX_DEST_WIDTH = 2048;
	localparam int unsigned MAX_DEST_HEIGHT = 2048;
	localparam int unsigned LINE_AW = $clog2(MAX_DEST_WIDTH);
	localparam int unsigned DIM_W = 12;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PSUM_W = CHAN_W + 1;
	localparam int unsigned LINE_W = 3 * PSUM_W;
	localparam int unsigned PIX_W = 3 * CHAN_W;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_DEST_WIDTH = 1'b0;
	localparam logic REG_DEST_HEIGHT = 1'b1;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PSUM_W-1:0] psum_t;
	typedef logic [LINE_W-1:0] line_t;
	typedef logic [DIM_W-1:0] dim_t;

	// Clamp a size register to 1..hi and return size - 1.
	function automatic logic [LINE_AW-1:0] dim_m1(input dim_t v, input dim_t hi);
		logic [LINE_AW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > hi) begin
			r = LINE_AW'(hi - 1'b1);
		end else begin
			r = LINE_AW'(v - 1'b1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/box_filter_mip_downsampler_unit.sv =====
// Top level: 2x2 box filter mip downsampler with line store of pair sums.
//
// channel | signals                                  | role
// --------+------------------------------------------+---------------------------
// in      | in_valid, in_stall, red/green/blue_in    | source pixels, raster order
// out     | out_valid, out_stall, red/green/blue_out,| one averaged pixel per
//         | last_pixel                               | 2x2 block
// apb     | psel, penable, pwrite, paddr, pwdata ... | dest_width 0x0, dest_height 0x4
//
// One pixel per clock while in_stall is low; one store access per pixel pair
// (write on even rows, read on odd rows); the read data is registered beside stage 1.
// Reset clears counters and valids; the line store needs no clearing.
// A stalled output holds the result register; a second block then stalls in.
// A register write restarts the frame at row 0, column 0.
`include "box_filter_mip_downsampler_unit_macros.svh"

module box_filter_mip_downsampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bfmd_pkg::chan_t                  red_in,
	input  bfmd_pkg::chan_t                  green_in,
	input  bfmd_pkg::chan_t                  blue_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bfmd_pkg::chan_t                  red_out,
	output bfmd_pkg::chan_t                  green_out,
	output bfmd_pkg::chan_t                  blue_out,
	output logic                             last_pixel,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bfmd_pkg::PADDR_W-1:0]     paddr,
	input  logic [bfmd_pkg::PDATA_W-1:0]     pwdata,
	output logic [bfmd_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	import bfmd_pkg::*;

	dim_t                width_q;
	dim_t                height_q;
	logic [DIM_W-1:0]    col_q;
	logic [DIM_W-1:0]    row_q;
	logic [PIX_W-1:0]    left_q;
	logic [LINE_AW-1:0]  w_m1;
	logic [LINE_AW-1:0]  h_m1;
	logic                cfg_wr;
	logic                in_acc;
	logic                col_end;
	logic                row_end;
	logic                blk_done;
	logic                line_we;
	line_t               pair_sum;
	line_t               line_rd;
	logic                s1_v_q;
	line_t               pair_s1;
	logic                last_s1;
	logic                out_v_q;
	logic                out_free;
	psum_t               sum_r;
	psum_t               sum_g;
	psum_t               sum_b;
	logic [PSUM_W:0]     tot_r;
	logic [PSUM_W:0]     tot_g;
	logic [PSUM_W:0]     tot_b;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_DEST_HEIGHT) ? PDATA_W'(height_q) : PDATA_W'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(MAX_DEST_WIDTH);
			height_q <= DIM_W'(MAX_DEST_HEIGHT);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DEST_HEIGHT) begin
				height_q <= pwdata[DIM_W-1:0];
			end else begin
				width_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	assign w_m1 = dim_m1(width_q, DIM_W'(MAX_DEST_WIDTH));
	assign h_m1 = dim_m1(height_q, DIM_W'(MAX_DEST_HEIGHT));

	// handshake
	assign out_free = !out_v_q || !out_stall;
	assign in_stall = s1_v_q && !out_free;
	assign in_acc = in_valid && !in_stall;

	// position counters
	assign col_end = col_q[0] && (col_q[DIM_W-1:1] == w_m1);
	assign row_end = row_q[0] && (row_q[DIM_W-1:1] == h_m1);
	assign blk_done = col_q[0] && row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !col_q[0]) begin
			left_q <= {blue_in, green_in, red_in};
		end
	end

	// horizontal pair sum, packed red in the low bits
	assign pair_sum = {
		PSUM_W'(left_q[3*CHAN_W-1:2*CHAN_W]) + PSUM_W'(blue_in),
		PSUM_W'(left_q[2*CHAN_W-1:CHAN_W]) + PSUM_W'(green_in),
		PSUM_W'(left_q[CHAN_W-1:0]) + PSUM_W'(red_in)
	};

	assign line_we = in_acc && col_q[0] && !row_q[0];

	bfmd_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_DEST_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(col_q[DIM_W-1:1]),
		.wdata(pair_sum),
		.re   (in_acc && blk_done),
		.raddr(col_q[DIM_W-1:1]),
		.rdata(line_rd)
	);

	// stage 1: pair sum of the odd row beside the stored even-row sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= blk_done;
		end else if (out_free) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && blk_done) begin
			pair_s1 <= pair_sum;
			last_s1 <= col_end && row_end;
		end
	end

	assign sum_r = line_rd[PSUM_W-1:0];
	assign sum_g = line_rd[2*PSUM_W-1:PSUM_W];
	assign sum_b = line_rd[3*PSUM_W-1:2*PSUM_W];
	assign tot_r = (PSUM_W+1)'(sum_r) + (PSUM_W+1)'(pair_s1[PSUM_W-1:0]);
	assign tot_g = (PSUM_W+1)'(sum_g) + (PSUM_W+1)'(pair_s1[2*PSUM_W-1:PSUM_W]);
	assign tot_b = (PSUM_W+1)'(sum_b) + (PSUM_W+1)'(pair_s1[3*PSUM_W-1:2*PSUM_W]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_v_q) begin
			red_out <= tot_r[PSUM_W:2];
			green_out <= tot_g[PSUM_W:2];
			blue_out <= tot_b[PSUM_W:2];
			last_pixel <= last_s1;
		end
	end

	assign out_valid = out_v_q;

	`BFMD_ASSERT(a_no_result_off_block, clk, arst_n, in_acc && !blk_done |=> !s1_v_q, "result started by a pixel that does not end a block")
	`BFMD_ASSERT(a_frame_wrap, clk, arst_n, in_acc && !cfg_wr && col_end && row_end |=> col_q == '0 && row_q == '0, "counters did not wrap after last source pixel")
	`BFMD_ASSERT(a_s1_held, clk, arst_n, s1_v_q && out_v_q && out_stall |=> s1_v_q && $stable(pair_s1), "stage 1 lost a pending block while output stalled")
	`BFMD_ASSERT(a_no_rw_clash, clk, arst_n, !(line_we && in_acc && blk_done), "line store written and read by one pixel")

endmodule

// ===== rtl/bfmd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bfmd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sim/box_filter_mip_downsampler_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for the 2x2 box filter mip downsampler: pixel streams checked against predicted averages.
module box_filter_mip_downsampler_unit_test;
	import bfmd_pkg::*;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last;
	} average_t;

	localparam logic [PADDR_W-1:0] ADDR_DEST_WIDTH = {REG_DEST_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_DEST_HEIGHT = {REG_DEST_HEIGHT, 2'b00};
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PIXELS_PER_PHASE = 280;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;
	logic out_valid;
	logic out_stall;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	logic last_pixel;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// predicted block state
	dim_t width_reg;
	dim_t height_reg;
	line_t pair_sums [MAX_DEST_WIDTH];
	pixel_t left_px;
	int unsigned src_col;
	int unsigned src_row;
	average_t expected_averages[$];

	int error_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_cycles = 0;
	average_t got_average;
	average_t want_average;

	box_filter_mip_downsampler_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.last_pixel(last_pixel),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	function automatic int unsigned clamp_size(input dim_t v, input int unsigned hi);
		if (v == '0) begin
			return 1;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Advances the predicted state by one source pixel; queues an average on block completion.
	task automatic average_block(input pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned slot;
		psum_t pr;
		psum_t pg;
		psum_t pb;
		logic [PSUM_W:0] tr;
		logic [PSUM_W:0] tg;
		logic [PSUM_W:0] tb;
		line_t stored;
		average_t avg;
		w = clamp_size(width_reg, MAX_DEST_WIDTH);
		h = clamp_size(height_reg, MAX_DEST_HEIGHT);
		if (src_col[0] == 1'b0) begin
			left_px = px;
		end else begin
			pr = {1'b0, left_px.red} + {1'b0, px.red};
			pg = {1'b0, left_px.green} + {1'b0, px.green};
			pb = {1'b0, left_px.blue} + {1'b0, px.blue};
			slot = (src_col >> 1) % MAX_DEST_WIDTH;
			if (src_row[0] == 1'b0) begin
				pair_sums[slot] = {pb, pg, pr};
			end else begin
				stored = pair_sums[slot];
				tr = {1'b0, stored[PSUM_W-1:0]} + {1'b0, pr};
				tg = {1'b0, stored[2*PSUM_W-1:PSUM_W]} + {1'b0, pg};
				tb = {1'b0, stored[3*PSUM_W-1:2*PSUM_W]} + {1'b0, pb};
				avg.red = tr[PSUM_W:2];
				avg.green = tg[PSUM_W:2];
				avg.blue = tb[PSUM_W:2];
				avg.last = (src_col + 1 >= 2 * w) && (src_row + 1 >= 2 * h);
				expected_averages.push_back(avg);
			end
		end
		src_col++;
		if (src_col >= 2 * w) begin
			src_col = 0;
			src_row++;
			if (src_row >= 2 * h) begin
				src_row = 0;
			end
		end
	endtask

	task automatic send_pixel(input pixel_t px);
		if ($urandom_range(99, 0) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		red_in <= px.red;
		green_in <= px.green;
		blue_in <= px.blue;
		do @(posedge clk); while (in_stall);
		average_block(px);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		px = pixel_t'($urandom);
		case ($urandom_range(7, 0))
			0: px = '0;
			1: px = '1;
			default: ;
		endcase
		return px;
	endfunction

	task automatic send_random_pixels(input int unsigned count);
		repeat (count) send_pixel(random_pixel());
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_register(input logic [PADDR_W-1:0] addr, input dim_t want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[DIM_W-1:0] !== want) begin
			note_error($sformatf("register 0x%0h read %0d, expected %0d",
				addr, prdata[DIM_W-1:0], want));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(input logic [PADDR_W-1:0] addr, input dim_t value);
		logic [PDATA_W-1:0] data;
		data = $urandom;
		data[DIM_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_DEST_WIDTH) begin
			width_reg = value;
		end else begin
			height_reg = value;
		end
		src_col = 0;
		src_row = 0;
		check_register(addr, value);
	endtask

	task automatic set_size(input dim_t w, input dim_t h);
		drain_results();
		write_register(ADDR_DEST_WIDTH, w);
		write_register(ADDR_DEST_HEIGHT, h);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles--;
		end else begin
			out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_average = {red_out, green_out, blue_out, last_pixel};
			if (expected_averages.size() == 0) begin
				note_error($sformatf("unexpected result %0d/%0d/%0d last %0b",
					red_out, green_out, blue_out, last_pixel));
			end else begin
				want_average = expected_averages.pop_front();
				if (got_average !== want_average) begin
					note_error($sformatf("result %0d/%0d/%0d last %0b, expected %0d/%0d/%0d last %0b",
						got_average.red, got_average.green, got_average.blue, got_average.last,
						want_average.red, want_average.green, want_average.blue,
						want_average.last));
				end
			end
		end
	end

	task automatic test_reset_values();
		check_register(ADDR_DEST_WIDTH, dim_t'(MAX_DEST_WIDTH));
		check_register(ADDR_DEST_HEIGHT, dim_t'(MAX_DEST_HEIGHT));
		send_random_pixels(10);
		drain_results();
	endtask

	// saturated blocks, zero blocks, truncation, and the 1x1 clamp of zero sizes
	task automatic test_corner_blocks();
		pixel_t corner_pixels [16];
		pixel_t tiny_pixels [4];
		corner_pixels = '{
			24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
			24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
			24'h030201, 24'h000000, 24'h8000FF, 24'h030303,
			24'h000000, 24'h000000, 24'h7FFF00, 24'h020303
		};
		tiny_pixels = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFEFEFE};
		set_idling(0, 0);
		set_size(2, 2);
		foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
		set_size(0, 0);
		foreach (tiny_pixels[i]) send_pixel(tiny_pixels[i]);
		drain_results();
	endtask

	// a register write part way through a frame starts a new one
	task automatic test_frame_restart();
		set_idling(13, 13);
		set_size(3, 2);
		send_random_pixels(9);
		drain_results();
		write_register(ADDR_DEST_HEIGHT, 2);
		send_random_pixels(24);
		send_random_pixels(24);
		drain_results();
	endtask

	// out-of-range height clamps to the tallest frame; the start of such a frame
	task automatic test_size_clamp();
		set_idling(13, 13);
		set_size(1, dim_t'('1));
		send_random_pixels(256);
		drain_results();
	endtask

	task automatic test_output_backpressure();
		set_idling(0, 0);
		set_size(4, 4);
		hold_off_cycles = 200;
		send_random_pixels(128);
		drain_results();
		send_random_pixels(64);
		drain_results();
	endtask

	task automatic test_random_frames(input int sender_pct, input int receiver_pct);
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned pixels;
		sent = 0;
		set_idling(sender_pct, receiver_pct);
		while (sent < RANDOM_PIXELS_PER_PHASE) begin
			if ($urandom_range(7, 0) == 0) begin
				w = $urandom_range(40, 9);
				h = 1;
			end else begin
				w = $urandom_range(8, 1);
				h = $urandom_range(4, 1);
			end
			set_size(dim_t'(w), dim_t'(h));
			pixels = 4 * w * h * $urandom_range(2, 1);
			if ($urandom_range(4, 0) == 0) begin
				pixels = $urandom_range(pixels - 1, 1);
			end
			send_random_pixels(pixels);
			sent += pixels;
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		width_reg = dim_t'(MAX_DEST_WIDTH);
		height_reg = dim_t'(MAX_DEST_HEIGHT);
		left_px = '0;
		src_col = 0;
		src_row = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_corner_blocks();
		test_frame_restart();
		test_output_backpressure();
		test_size_clamp();
		test_random_frames(0, 0);
		test_random_frames(63, 0);
		test_random_frames(0, 63);
		test_random_frames(13, 13);

		set_idling(0, 0);
		drain_results();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfmd_pkg.sv
rtl/bfmd_ram.sv
rtl/box_filter_mip_downsampler_unit.sv
sim/box_filter_mip_downsampler_unit_test.sv
